// ===== hw/rtl/u16t8_pkg.sv =====
package u16t8_pkg;

  localparam int MAX_UNITS_DEF = 40;
  localparam int OUT_BYTES_DEF = 160;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [15:0] HIGH_FIRST = 16'hd800;
  localparam logic [15:0] HIGH_LAST  = 16'hdbff;
  localparam logic [15:0] LOW_FIRST  = 16'hdc00;
  localparam logic [15:0] LOW_LAST   = 16'hdfff;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00fffd;
  localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;

  localparam int DATA_W = 72;
  localparam int USER_W = 2;

  // number of utf-8 bytes for a code point
  function automatic logic [2:0] cp_need(input logic [20:0] cp);
    logic [2:0] n;
    if (cp <= 21'h00007f) begin
      n = 3'd1;
    end else if (cp <= 21'h0007ff) begin
      n = 3'd2;
    end else if (cp <= 21'h00ffff) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  // one utf-8 byte of a code point
  function automatic logic [7:0] cp_byte(input logic [20:0] cp, input logic [2:0] need,
                                         input logic [1:0] idx);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    case (need)
      3'd1: b = cp[7:0];
      3'd2: begin
        if (idx == 2'd0) b = {3'b110, cp[10:6]};
      end
      3'd3: begin
        if (idx == 2'd0) b = {4'b1110, cp[15:12]};
        else if (idx == 2'd1) b = {2'b10, cp[11:6]};
      end
      default: begin
        if (idx == 2'd0) b = {5'b11110, cp[20:18]};
        else if (idx == 2'd1) b = {2'b10, cp[17:12]};
        else if (idx == 2'd2) b = {2'b10, cp[11:6]};
      end
    endcase
    return b;
  endfunction

  // ascii whitespace
  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
  endfunction

endpackage

// ===== hw/rtl/utf16_title_to_utf8_decoder_unit.sv =====
// Transcodes a title given as UTF-16 code units (one per transaction, tlast on the final unit)
// into UTF-8 held in an internal byte memory of OUT_BYTES entries, then trims ASCII
// whitespace at both ends and sends the text as results of up to eight bytes, or a single
// empty or overflow status. The memory has one write and one read port, one byte each per
// cycle. A unit is registered in S_IDLE and its UTF-8 bytes are then written in S_PUT; a code
// point that does not fit is not written and marks the title as overflowed. After the last unit
// the trim removes whitespace from the front (S_TF, S_TFW) and then the back (S_TB, S_TBW), and
// the output pass reads the bytes in S_ER and S_EW, stalling while a result waits to be taken.
// A new title is accepted once the last result has been loaded into the output register.
module utf16_title_to_utf8_decoder_unit #(
  parameter int MAX_UNITS = u16t8_pkg::MAX_UNITS_DEF,
  parameter int OUT_BYTES = u16t8_pkg::OUT_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,  // code_unit[15:0]
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [u16t8_pkg::DATA_W-1:0] m_tdata,  // text_bytes[63:0], byte_count[67:64], zero
  output logic [u16t8_pkg::USER_W-1:0] m_tuser,  // status[1:0]
  output logic                         m_tlast
);

  localparam int AW = $clog2(OUT_BYTES);
  localparam int LW = $clog2(OUT_BYTES + 1);
  localparam int UW = $clog2(MAX_UNITS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PUT  = 4'd1;
  localparam logic [3:0] S_TF   = 4'd2;
  localparam logic [3:0] S_TFW  = 4'd3;
  localparam logic [3:0] S_TB   = 4'd4;
  localparam logic [3:0] S_TBW  = 4'd5;
  localparam logic [3:0] S_ER   = 4'd6;
  localparam logic [3:0] S_EW   = 4'd7;
  localparam logic [3:0] S_STAT = 4'd8;

  logic [7:0]    mem [OUT_BYTES];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [7:0]    wr_data;

  logic [3:0]    state;
  logic [LW-1:0] out_length;
  logic [9:0]    held_high;
  logic          high_pending;
  logic [UW-1:0] units_seen;
  logic          text_ended;
  logic          overflowed;
  logic          last_q;
  logic [20:0]   cp_a;
  logic [20:0]   cp_b;
  logic          has_a;
  logic          has_b;
  logic [1:0]    byte_idx;
  logic [LW-1:0] first;
  logic [LW-1:0] last_end;
  logic [63:0]   word;
  logic [3:0]    cnt;
  logic [1:0]    stat_code;

  logic [63:0]   text_bytes;
  logic [3:0]    byte_count;

  // unit decode
  logic          is_high;
  logic          is_low;
  logic          take;
  logic [1:0]    d_n;
  logic [20:0]   d_cp_a;
  logic [20:0]   d_cp_b;
  logic          d_pend;
  logic [9:0]    d_held;
  logic          d_ended;
  logic [20:0]   d_push;

  logic          accept;
  logic          out_free;
  logic          out_load;
  logic [2:0]    need;
  logic [LW:0]   fill_sum;
  logic [LW-1:0] end_m1;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = ((state == S_ER) && (first == last_end || cnt == 4'd8) && out_free)
                    || ((state == S_STAT) && out_free);
  assign need     = u16t8_pkg::cp_need(cp_a);
  assign fill_sum = {1'b0, out_length} + (LW + 1)'(need);
  assign end_m1   = last_end - LW'(1);
  assign wr_data  = u16t8_pkg::cp_byte(cp_a, need, byte_idx);

  assign m_tdata  = {4'd0, byte_count, text_bytes};

  always_comb begin
    is_high = (s_tdata >= u16t8_pkg::HIGH_FIRST) && (s_tdata <= u16t8_pkg::HIGH_LAST);
    is_low  = (s_tdata >= u16t8_pkg::LOW_FIRST) && (s_tdata <= u16t8_pkg::LOW_LAST);
    take    = !text_ended && !overflowed && (units_seen < UW'(MAX_UNITS));
    d_n     = 2'd0;
    d_cp_a  = u16t8_pkg::CP_REPLACEMENT;
    d_cp_b  = u16t8_pkg::CP_REPLACEMENT;
    d_pend  = high_pending;
    d_held  = held_high;
    d_ended = text_ended;
    d_push  = u16t8_pkg::CP_REPLACEMENT;
    if (take) begin
      if (high_pending && is_low) begin
        d_cp_a = u16t8_pkg::CP_SUPP_BASE + {1'b0, held_high, s_tdata[9:0]};
        d_n    = 2'd1;
        d_pend = 1'b0;
        d_held = 10'd0;
      end else begin
        if (high_pending) begin
          d_n    = 2'd1;
          d_pend = 1'b0;
          d_held = 10'd0;
        end
        if (s_tdata == 16'd0) begin
          d_ended = 1'b1;
        end else if (is_high) begin
          if (units_seen >= UW'(MAX_UNITS - 1)) begin
            if (d_n == 2'd0) d_cp_a = u16t8_pkg::CP_REPLACEMENT;
            else d_cp_b = u16t8_pkg::CP_REPLACEMENT;
            d_n = d_n + 2'd1;
          end else begin
            d_held = s_tdata[9:0];
            d_pend = 1'b1;
          end
        end else begin
          d_push = is_low ? u16t8_pkg::CP_REPLACEMENT : {5'd0, s_tdata};
          if (d_n == 2'd0) d_cp_a = d_push;
          else d_cp_b = d_push;
          d_n = d_n + 2'd1;
        end
      end
    end
    if (s_tlast && d_pend) begin
      if (d_n == 2'd0) d_cp_a = u16t8_pkg::CP_REPLACEMENT;
      else d_cp_b = u16t8_pkg::CP_REPLACEMENT;
      d_n    = d_n + 2'd1;
      d_pend = 1'b0;
    end
  end

  always_comb begin
    wr_en = 1'b0;
    if (state == S_PUT && has_a && !(byte_idx == 2'd0 &&
        (overflowed || fill_sum > (LW + 1)'(OUT_BYTES)))) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    unique case (state)
      S_TB:    rd_addr = end_m1[AW-1:0];
      default: rd_addr = first[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[out_length[AW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_length   <= '0;
      held_high    <= '0;
      high_pending <= 1'b0;
      units_seen   <= '0;
      text_ended   <= 1'b0;
      overflowed   <= 1'b0;
      has_a        <= 1'b0;
      has_b        <= 1'b0;
      byte_idx     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_q       <= s_tlast;
            cp_a         <= d_cp_a;
            cp_b         <= d_cp_b;
            has_a        <= (d_n != 2'd0);
            has_b        <= (d_n == 2'd2);
            byte_idx     <= '0;
            high_pending <= d_pend;
            held_high    <= d_held;
            text_ended   <= d_ended;
            if (take) begin
              units_seen <= units_seen + UW'(1);
            end
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (!has_a) begin
            first    <= '0;
            last_end <= out_length;
            if (!last_q) begin
              state <= S_IDLE;
            end else if (overflowed) begin
              stat_code <= u16t8_pkg::STATUS_OVERFLOW;
              state     <= S_STAT;
            end else begin
              state <= S_TF;
            end
          end else if (!wr_en) begin
            overflowed <= 1'b1;
            has_a      <= 1'b0;
            has_b      <= 1'b0;
          end else begin
            out_length <= out_length + LW'(1);
            if ({1'b0, byte_idx} == need - 3'd1) begin
              cp_a     <= cp_b;
              has_a    <= has_b;
              has_b    <= 1'b0;
              byte_idx <= '0;
            end else begin
              byte_idx <= byte_idx + 2'd1;
            end
          end
        end
        S_TF: begin
          if (first == last_end) begin
            stat_code <= u16t8_pkg::STATUS_EMPTY;
            state     <= S_STAT;
          end else begin
            state <= S_TFW;
          end
        end
        S_TFW: begin
          if (u16t8_pkg::is_blank(rd_data)) begin
            first <= first + LW'(1);
            state <= S_TF;
          end else begin
            state <= S_TB;
          end
        end
        S_TB: begin
          state <= S_TBW;
        end
        S_TBW: begin
          if (u16t8_pkg::is_blank(rd_data)) begin
            last_end <= end_m1;
            state    <= S_TB;
          end else begin
            word  <= '0;
            cnt   <= '0;
            state <= S_ER;
          end
        end
        S_ER: begin
          if (first == last_end || cnt == 4'd8) begin
            if (out_free) begin
              text_bytes <= word;
              byte_count <= cnt;
              m_tuser    <= u16t8_pkg::STATUS_OK;
              m_tlast    <= (first == last_end);
              word       <= '0;
              cnt        <= '0;
              if (first == last_end) begin
                out_length   <= '0;
                held_high    <= '0;
                high_pending <= 1'b0;
                units_seen   <= '0;
                text_ended   <= 1'b0;
                overflowed   <= 1'b0;
                state        <= S_IDLE;
              end
            end
          end else begin
            first <= first + LW'(1);
            state <= S_EW;
          end
        end
        S_EW: begin
          word[cnt[2:0]*8 +: 8] <= rd_data;
          cnt                   <= cnt + 4'd1;
          state                 <= S_ER;
        end
        S_STAT: begin
          if (out_free) begin
            text_bytes   <= '0;
            byte_count   <= '0;
            m_tuser      <= stat_code;
            m_tlast      <= 1'b1;
            out_length   <= '0;
            held_high    <= '0;
            high_pending <= 1'b0;
            units_seen   <= '0;
            text_ended   <= 1'b0;
            overflowed   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/u16t8_checker.sv =====
module u16t8_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [u16t8_pkg::DATA_W-1:0] m_tdata,
  input logic [u16t8_pkg::USER_W-1:0] m_tuser,
  input logic                         m_tlast
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // a status result is alone and carries no bytes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != u16t8_pkg::STATUS_OK |-> m_tlast && m_tdata == '0)
    else $error("status result with data");

  // text words carry one to eight bytes, full unless final
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == u16t8_pkg::STATUS_OK |->
      m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd8
      && (m_tlast || m_tdata[67:64] == 4'd8))
    else $error("bad byte count");

  // status code range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == u16t8_pkg::STATUS_OK || m_tuser == u16t8_pkg::STATUS_EMPTY
      || m_tuser == u16t8_pkg::STATUS_OVERFLOW)
    else $error("bad status");

endmodule

bind utf16_title_to_utf8_decoder_unit u16t8_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== tb/sv/utf8_title_checker.sv =====
module utf8_title_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [15:0]                  s_tdata,
  input  logic                         s_tlast,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [u16t8_pkg::DATA_W-1:0] m_tdata,
  input  logic [u16t8_pkg::USER_W-1:0] m_tuser,
  input  logic                         m_tlast,
  output int                           error_count,
  output int                           pending_words,
  output int                           words_checked,
  output int                           titles_done
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_UNITS = u16t8_pkg::MAX_UNITS_DEF;
  localparam int OUT_BYTES = u16t8_pkg::OUT_BYTES_DEF;

  typedef struct packed {
    logic [63:0] text;
    logic [3:0]  count;
    logic [1:0]  status;
    logic        fin;
  } title_word_t;

  title_word_t expected_words[$];

  logic [7:0] utf8_store [OUT_BYTES];
  int         store_len;
  logic [9:0] held_high;
  bit         high_pending;
  int         units_taken;
  bit         text_done;
  bit         store_full;

  function automatic bit is_space_byte(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function void clear_title();
    store_len    = 0;
    held_high    = '0;
    high_pending = 0;
    units_taken  = 0;
    text_done    = 0;
    store_full   = 0;
  endfunction

  function void push_byte(input logic [7:0] b);
    utf8_store[store_len] = b;
    store_len++;
  endfunction

  function void append_code_point(input logic [20:0] cp);
    int need;
    if (store_full) return;
    if (cp <= 21'h7f) need = 1;
    else if (cp <= 21'h7ff) need = 2;
    else if (cp <= 21'hffff) need = 3;
    else need = 4;
    if (OUT_BYTES - store_len < need) begin
      store_full = 1;
      return;
    end
    case (need)
      1: push_byte(cp[7:0]);
      2: begin
        push_byte({3'b110, cp[10:6]});
        push_byte({2'b10, cp[5:0]});
      end
      3: begin
        push_byte({4'b1110, cp[15:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
      default: begin
        push_byte({5'b11110, cp[20:18]});
        push_byte({2'b10, cp[17:12]});
        push_byte({2'b10, cp[11:6]});
        push_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function void take_code_unit(input logic [15:0] cu);
    bit is_high;
    bit is_low;
    is_high = (cu >= u16t8_pkg::HIGH_FIRST) && (cu <= u16t8_pkg::HIGH_LAST);
    is_low  = (cu >= u16t8_pkg::LOW_FIRST) && (cu <= u16t8_pkg::LOW_LAST);
    units_taken++;
    if (high_pending) begin
      high_pending = 0;
      if (is_low) begin
        append_code_point(u16t8_pkg::CP_SUPP_BASE + {1'b0, held_high, cu[9:0]});
        held_high = '0;
        return;
      end
      held_high = '0;
      append_code_point(u16t8_pkg::CP_REPLACEMENT);
      if (store_full) return;
    end
    if (cu == 16'h0000) begin
      text_done = 1;
    end else if (is_high) begin
      if (units_taken >= MAX_UNITS) begin
        append_code_point(u16t8_pkg::CP_REPLACEMENT);
      end else begin
        held_high    = cu[9:0];
        high_pending = 1;
      end
    end else if (is_low) begin
      append_code_point(u16t8_pkg::CP_REPLACEMENT);
    end else begin
      append_code_point({5'd0, cu});
    end
  endfunction

  function void finish_title();
    int          lo;
    int          hi;
    int          n;
    logic [63:0] word;
    if (high_pending) begin
      high_pending = 0;
      append_code_point(u16t8_pkg::CP_REPLACEMENT);
    end
    if (store_full) begin
      expected_words.push_back('{64'd0, 4'd0, u16t8_pkg::STATUS_OVERFLOW, 1'b1});
    end else begin
      lo = 0;
      hi = store_len;
      while (lo < hi && is_space_byte(utf8_store[lo])) lo++;
      while (hi > lo && is_space_byte(utf8_store[hi-1])) hi--;
      if (lo == hi) begin
        expected_words.push_back('{64'd0, 4'd0, u16t8_pkg::STATUS_EMPTY, 1'b1});
      end
      while (lo < hi) begin
        n = (hi - lo > 8) ? 8 : hi - lo;
        word = '0;
        for (int i = 0; i < n; i++) begin
          word = word | ({56'd0, utf8_store[lo+i]} << (8 * i));
        end
        lo += n;
        expected_words.push_back('{word, 4'(n), u16t8_pkg::STATUS_OK, lo >= hi});
      end
    end
    clear_title();
    titles_done++;
  endfunction

  function void check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    title_word_t want;
    if (rst) begin
      clear_title();
      expected_words.delete();
      error_count   = 0;
      words_checked = 0;
      titles_done   = 0;
      pending_words <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (!text_done && !store_full && units_taken < MAX_UNITS) take_code_unit(s_tdata);
        if (s_tlast) finish_title();
      end
      if (m_tvalid && m_tready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          error_count++;
          $display("%0t unexpected transaction: expected none actual tdata %h tuser %h tlast %b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = expected_words.pop_front();
          check_field("text_bytes", want.text, m_tdata[63:0]);
          check_field("byte_count", 64'(want.count), 64'(m_tdata[67:64]));
          check_field("tdata padding", 64'd0, 64'(m_tdata[u16t8_pkg::DATA_W-1:68]));
          check_field("status", 64'(want.status), 64'(m_tuser));
          check_field("final_res", 64'(want.fin), 64'(m_tlast));
        end
      end
      pending_words <= expected_words.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u16t8_pkg::*;

  localparam int RANDOM_UNITS  = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 40;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [15:0]         s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [DATA_W-1:0]   m_tdata;
  logic [USER_W-1:0]   m_tuser;
  logic                m_tlast;

  int error_count;
  int pending_words;
  int words_checked;
  int titles_done;

  int          gap_pct;
  int          stall_pct;
  int          units_sent;
  int          quiet_cycles;
  logic [15:0] title_units[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  utf16_title_to_utf8_decoder_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  utf8_title_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .error_count   (error_count),
    .pending_words (pending_words),
    .words_checked (words_checked),
    .titles_done   (titles_done)
  );

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function void set_idle_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct   = 69;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct   = 0;
        stall_pct = 69;
      end
      default: begin
        gap_pct   = 7;
        stall_pct = 7;
      end
    endcase
  endfunction

  // called right after a falling edge; returns right after the falling edge past acceptance
  task automatic send_unit(input logic [15:0] cu, input logic lst);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cu;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    units_sent++;
    @(negedge clk);
  endtask

  task automatic send_title();
    for (int i = 0; i < title_units.size(); i++) begin
      send_unit(title_units[i], i == title_units.size() - 1);
    end
  endtask

  task automatic build_random_title();
    int          len;
    int          shape;
    int          pick;
    logic [15:0] cu;
    title_units.delete();
    shape = $urandom_range(0, 19);
    if (shape == 0) len = $urandom_range(38, 45);
    else if (shape == 1) len = 1;
    else len = $urandom_range(1, 12);
    while (title_units.size() < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        title_units.push_back(16'($urandom_range(16'h21, 16'h7e)));
      end else if (pick < 35) begin
        cu = 16'($urandom_range(0, 5));
        title_units.push_back(cu == 16'd5 ? 16'h0020 : 16'h0009 + cu);
      end else if (pick < 45) begin
        title_units.push_back(16'($urandom_range(16'h80, 16'h7ff)));
      end else if (pick < 55) begin
        cu = 16'($urandom_range(16'h800, 16'hffff));
        if (cu >= HIGH_FIRST && cu <= LOW_LAST) cu = cu ^ 16'h4000;
        title_units.push_back(cu);
      end else if (pick < 70) begin
        title_units.push_back(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
        title_units.push_back(16'($urandom_range(LOW_FIRST, LOW_LAST)));
      end else if (pick < 75) begin
        title_units.push_back(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
      end else if (pick < 80) begin
        title_units.push_back(16'($urandom_range(LOW_FIRST, LOW_LAST)));
      end else if (pick < 82) begin
        title_units.push_back(16'h0000);
      end else begin
        title_units.push_back(16'($urandom_range(0, 16'hffff)));
      end
    end
    // high surrogate landing on the last unit that still counts
    if (shape == 0 && title_units.size() >= MAX_UNITS_DEF && $urandom_range(0, 1) == 1) begin
      title_units[MAX_UNITS_DEF-1] = 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
    end
  endtask

  initial begin
    int drain;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tlast    <= 1'b0;
    units_sent = 0;
    set_idle_mode(IDLE_NONE);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // encoding length edges, whitespace at both ends
    title_units = '{16'h0020, 16'h0001, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hffff,
                    16'h0009};
    send_title();
    // valid pair, lone low, unpaired high, high at the end
    title_units = '{16'hd83d, 16'hde00, 16'hdc00, 16'hdbff, 16'h0041, 16'hd800};
    send_title();
    // only whitespace
    title_units = '{16'h000d, 16'h000a, 16'h000b, 16'h000c, 16'h0020};
    send_title();
    // zero unit ends the text
    title_units = '{16'h0042, 16'h0000, 16'h0043};
    send_title();
    title_units = '{16'h0000};
    send_title();
    title_units = '{16'hdbff, 16'hdfff};
    send_title();

    while (units_sent < 25 + RANDOM_UNITS) begin
      case ((units_sent - 25) * 4 / RANDOM_UNITS)
        0: set_idle_mode(IDLE_NONE);
        1: set_idle_mode(IDLE_SENDER);
        2: set_idle_mode(IDLE_RECEIVER);
        default: set_idle_mode(IDLE_BOTH);
      endcase
      build_random_title();
      send_title();
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    drain = 0;
    @(posedge clk);
    while (pending_words != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d code units in %0d titles sent, %0d output transactions compared",
             units_sent, titles_done, words_checked);
    $display("idling phases: none, sender gaps, receiver stalls, light both");
    if (error_count == 0 && pending_words == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count, pending_words);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
